FILE: rtl/mad_pkg.sv
// shared constants for the moving average anomaly detector
`default_nettype none

package mad_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 10;
    localparam int unsigned TEMP_W           = 11;
    localparam int unsigned THR_W            = 11;
    localparam int unsigned MIN_SAMPLES      = 3;

    localparam logic [THR_W-1:0] THR_RESET = 11'd50;

endpackage

`default_nettype wire

FILE: rtl/mad_window.sv
// sample window memory with write position and fill count
`default_nettype none

module mad_window #(
    parameter int unsigned WINDOW_DEPTH = mad_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic signed [mad_pkg::TEMP_W-1:0]      i_sample_temp,
    input  wire logic                                   i_sample_valid,
    input  wire logic                                   i_next_en,
    output logic                                        o_v,
    output logic signed [mad_pkg::TEMP_W-1:0]           o_temp,
    output logic                                        o_svalid,
    output logic                                        o_full,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]           o_count,
    output logic signed [mad_pkg::TEMP_W-1:0]           o_old
);

    localparam int unsigned WP_W  = $clog2(WINDOW_DEPTH);
    localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH+1);

    logic signed [mad_pkg::TEMP_W-1:0] r_mem [WINDOW_DEPTH];
    logic [WP_W-1:0]                   r_wp;
    logic [WP_W-1:0]                   n_wp;
    logic [CNT_W-1:0]                  r_fill;
    logic [CNT_W-1:0]                  n_fill;
    logic                              r_v;
    logic                              w_accept;
    logic                              w_full;

    assign o_stall  = r_v && !i_next_en;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_fill == CNT_W'(WINDOW_DEPTH));
    assign o_v      = r_v;

    always_comb begin
        n_wp   = r_wp;
        n_fill = r_fill;
        if (w_accept && i_sample_valid) begin
            n_wp = (r_wp == WP_W'(WINDOW_DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (!w_full) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    // read-first: the old sample leaves as the new one goes in
    always_ff @(posedge i_clk) begin
        if (w_accept && i_sample_valid) begin
            r_mem[r_wp] <= i_sample_temp;
        end
        if (w_accept) begin
            o_old <= r_mem[r_wp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            o_temp   <= i_sample_temp;
            o_svalid <= i_sample_valid;
            o_full   <= w_full;
            o_count  <= w_full ? r_fill : r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_v    <= 1'b0;
        end else begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
            if (w_accept) begin
                r_v <= 1'b1;
            end else if (i_next_en) begin
                r_v <= 1'b0;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= WP_W'(WINDOW_DEPTH-1))
        else $error("write position beyond window");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_sample_valid && !w_full) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("fill count missed a sample");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && !i_next_en) |=> (r_v && $stable(o_temp) && $stable(o_svalid)))
        else $error("stage one lost a held item");

endmodule

`default_nettype wire

FILE: rtl/mad_accum.sv
// running window sum stage
`default_nettype none

module mad_accum #(
    parameter int unsigned WINDOW_DEPTH = mad_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_v,
    input  wire logic signed [mad_pkg::TEMP_W-1:0]      i_temp,
    input  wire logic                                   i_svalid,
    input  wire logic                                   i_full,
    input  wire logic [$clog2(WINDOW_DEPTH+1)-1:0]      i_count,
    input  wire logic signed [mad_pkg::TEMP_W-1:0]      i_old,
    output logic                                        o_en,
    input  wire logic                                   i_next_en,
    output logic                                        o_v,
    output logic signed [mad_pkg::TEMP_W-1:0]           o_temp,
    output logic                                        o_svalid,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]           o_count,
    output logic signed [mad_pkg::TEMP_W+$clog2(WINDOW_DEPTH+1)-1:0] o_sum
);

    localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH+1);
    localparam int unsigned SUM_W = mad_pkg::TEMP_W + CNT_W;
    localparam int unsigned EXT_W = SUM_W - mad_pkg::TEMP_W;

    logic                    r_v;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] w_new;
    logic signed [SUM_W-1:0] w_gone;
    logic                    w_take;

    assign o_en   = !r_v || i_next_en;
    assign w_take = i_v && o_en;
    assign o_v    = r_v;

    assign w_new  = {{EXT_W{i_temp[mad_pkg::TEMP_W-1]}}, i_temp};
    assign w_gone = i_full ? {{EXT_W{i_old[mad_pkg::TEMP_W-1]}}, i_old} : '0;

    always_comb begin
        n_sum = r_sum;
        if (w_take && i_svalid) begin
            n_sum = r_sum - w_gone + w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            o_temp   <= i_temp;
            o_svalid <= i_svalid;
            o_count  <= i_count;
            o_sum    <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
            if (w_take) begin
                r_v <= 1'b1;
            end else if (i_next_en) begin
                r_v <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mad_detect.sv
// threshold register, scaled products and deviation compare with output register
`default_nettype none

module mad_detect #(
    parameter int unsigned WINDOW_DEPTH = mad_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [mad_pkg::THR_W-1:0]              i_cfg_wdata,
    input  wire logic                                   i_v,
    input  wire logic signed [mad_pkg::TEMP_W-1:0]      i_temp,
    input  wire logic                                   i_svalid,
    input  wire logic [$clog2(WINDOW_DEPTH+1)-1:0]      i_count,
    input  wire logic signed [mad_pkg::TEMP_W+$clog2(WINDOW_DEPTH+1)-1:0] i_sum,
    output logic                                        o_en,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [mad_pkg::TEMP_W-1:0]           o_reported_temp,
    output logic                                        o_anomaly_flag
);

    localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH+1);
    localparam int unsigned SUM_W = mad_pkg::TEMP_W + CNT_W;
    localparam int unsigned DIF_W = SUM_W + 1;
    localparam int unsigned LIM_W = mad_pkg::THR_W + CNT_W;

    logic [mad_pkg::THR_W-1:0]         r_thr;
    logic                              r_v3;
    logic                              r_ov;
    logic signed [DIF_W-1:0]           r_prod;
    logic [LIM_W-1:0]                  r_lim;
    logic signed [SUM_W-1:0]           r_sum;
    logic signed [mad_pkg::TEMP_W-1:0] r_temp;
    logic                              r_svalid;
    logic                              r_chk;
    logic                              w_en_out;
    logic                              w_take;
    logic signed [DIF_W-1:0]           w_prod;
    logic signed [DIF_W-1:0]           w_diff;
    logic [DIF_W-1:0]                  w_abs;
    logic                              w_flag;

    assign w_en_out = !r_ov || !i_stall;
    assign o_en     = !r_v3 || w_en_out;
    assign w_take   = i_v && o_en;
    assign o_valid  = r_ov;

    assign w_prod = DIF_W'(i_temp) * DIF_W'($signed({1'b0, i_count}));

    // |sample*count - sum| against threshold*count, no division needed
    assign w_diff = r_prod - {r_sum[SUM_W-1], r_sum};
    assign w_abs  = w_diff[DIF_W-1] ? DIF_W'(-w_diff) : DIF_W'(w_diff);
    assign w_flag = r_svalid && r_chk && (w_abs > {{(DIF_W-LIM_W){1'b0}}, r_lim});

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_prod   <= w_prod;
            r_lim    <= LIM_W'(r_thr) * LIM_W'(i_count);
            r_sum    <= i_sum;
            r_temp   <= i_temp;
            r_svalid <= i_svalid;
            r_chk    <= (i_count >= CNT_W'(mad_pkg::MIN_SAMPLES));
        end
        if (r_v3 && w_en_out) begin
            o_reported_temp <= r_svalid ? r_temp : '0;
            o_anomaly_flag  <= w_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= mad_pkg::THR_RESET;
            r_v3  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (w_take) begin
                r_v3 <= 1'b1;
            end else if (w_en_out) begin
                r_v3 <= 1'b0;
            end
            if (r_v3 && w_en_out) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/moving_average_anomaly_detector_top.sv
// moving average anomaly detector: window memory, running sum, deviation compare
//
//  channel  | handshake         | payload
//  ---------+-------------------+--------------------------------------
//  input    | i_valid / o_stall | i_sample_temp, i_sample_valid
//  output   | o_valid / i_stall | o_reported_temp, o_anomaly_flag
//  config   | i_cfg_we          | i_cfg_wdata (deviation threshold)
//
// one sample per cycle sustained while the output is not stalled
// stages: window memory read-modify-write, running sum, scaled products, compare
// the window memory is read and written at the same slot in one cycle (read-first)
// synchronous active-low reset clears position, fill count and sum, sets threshold to 50
// stalls back up stage by stage; empty stages still take new transfers

`default_nettype none

module moving_average_anomaly_detector_top #(
    parameter int unsigned WINDOW_DEPTH = mad_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mad_pkg::THR_W-1:0]          i_cfg_wdata,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [mad_pkg::TEMP_W-1:0]  i_sample_temp,
    input  wire logic                               i_sample_valid,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [mad_pkg::TEMP_W-1:0]       o_reported_temp,
    output logic                                    o_anomaly_flag
);

    localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH+1);
    localparam int unsigned SUM_W = mad_pkg::TEMP_W + CNT_W;

    logic                              w_v1;
    logic signed [mad_pkg::TEMP_W-1:0] w_temp1;
    logic                              w_svalid1;
    logic                              w_full1;
    logic [CNT_W-1:0]                  w_count1;
    logic signed [mad_pkg::TEMP_W-1:0] w_old1;
    logic                              w_en2;
    logic                              w_v2;
    logic signed [mad_pkg::TEMP_W-1:0] w_temp2;
    logic                              w_svalid2;
    logic [CNT_W-1:0]                  w_count2;
    logic signed [SUM_W-1:0]           w_sum2;
    logic                              w_en3;

    mad_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_temp  (i_sample_temp),
        .i_sample_valid (i_sample_valid),
        .i_next_en      (w_en2),
        .o_v            (w_v1),
        .o_temp         (w_temp1),
        .o_svalid       (w_svalid1),
        .o_full         (w_full1),
        .o_count        (w_count1),
        .o_old          (w_old1)
    );

    mad_accum #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_v       (w_v1),
        .i_temp    (w_temp1),
        .i_svalid  (w_svalid1),
        .i_full    (w_full1),
        .i_count   (w_count1),
        .i_old     (w_old1),
        .o_en      (w_en2),
        .i_next_en (w_en3),
        .o_v       (w_v2),
        .o_temp    (w_temp2),
        .o_svalid  (w_svalid2),
        .o_count   (w_count2),
        .o_sum     (w_sum2)
    );

    mad_detect #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_detect (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_v             (w_v2),
        .i_temp          (w_temp2),
        .i_svalid        (w_svalid2),
        .i_count         (w_count2),
        .i_sum           (w_sum2),
        .o_en            (w_en3),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_reported_temp (o_reported_temp),
        .o_anomaly_flag  (o_anomaly_flag)
    );

endmodule

`default_nettype wire
